// ===== hdl/bfq_pkg.sv =====
// shared types and constants for the backpressure frame queue
// used by every module of the block; depends on nothing

package bfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W       = 16;
  localparam int BYTES_W     = 24;
  localparam int SUM_W       = BYTES_W + 1;
  localparam int OUT_W       = 5;

  localparam logic [BYTES_W-1:0] LIMIT_RESET = 24'd1048576;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DRAIN   = 1'b1;

  // m_tdata field offsets, lowest first
  localparam int OUT_DROP_LSB     = 0;
  localparam int OUT_RETIRED_BIT  = 5;
  localparam int OUT_BYTES_LSB    = 6;
  localparam int OUT_FRAMES_LSB   = 30;
  localparam int OUT_INTEREST_BIT = 35;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_OVER_LIMIT  = 3'd1,
    ST_NO_SLOT     = 3'd2,
    ST_DRAINED     = 3'd3,
    ST_DRAIN_EMPTY = 3'd4
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_CMP,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DEDUCT,
    S_CP_RD,
    S_CP_WR,
    S_APPEND,
    S_DR_RD,
    S_DR_EV,
    S_DR_SUB,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic             low_priority;
    logic [LEN_W-1:0] sent;
    logic [LEN_W-1:0] length;
  } slot_t;

  typedef struct packed {
    logic             cmd;
    logic [LEN_W-1:0] frame_length;
    logic             low_priority;
    logic [LEN_W-1:0] written_bytes;
  } item_t;

  typedef struct packed {
    status_t            status;
    cnt_t               dropped_frames;
    logic               head_retired;
    logic [BYTES_W-1:0] queued_bytes;
    cnt_t               queued_frames;
    logic               write_interest;
  } result_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    slot_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

endpackage

// ===== hdl/bfq_slot_ram.sv =====
// slot memory: one write port, one read port with registered read data
// depends on bfq_pkg

module bfq_slot_ram (
  input  logic              clk,
  input  bfq_pkg::ram_req_t req,
  output bfq_pkg::slot_t    rd_data
);

  bfq_pkg::slot_t mem [bfq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== hdl/bfq_alu.sv =====
// shared add/subtract unit for byte total arithmetic and the limit compare
// depends on bfq_pkg; msb of res is the carry or borrow

module bfq_alu (
  input  bfq_pkg::alu_req_t          req,
  output logic [bfq_pkg::SUM_W:0]    res
);

  always_comb begin
    case (req.op)
      bfq_pkg::ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
      bfq_pkg::ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
      default:          res = '0;
    endcase
  end

endmodule

// ===== hdl/bfq_seq.sv =====
// sequencer: scans, compacts and updates the slot memory one entry at a time
// depends on bfq_pkg; drives bfq_slot_ram and bfq_alu through request structs

module bfq_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bfq_pkg::item_t               in_item,
  input  logic [bfq_pkg::BYTES_W-1:0]  limit,
  output bfq_pkg::ram_req_t            ram_req,
  input  bfq_pkg::slot_t               ram_rd,
  output bfq_pkg::alu_req_t            alu_req,
  input  logic [bfq_pkg::SUM_W:0]      alu_res,
  output logic                         res_valid,
  input  logic                         res_ready,
  output bfq_pkg::result_t             res
);

  bfq_pkg::state_t state, state_next;
  bfq_pkg::cnt_t   count, count_next;
  bfq_pkg::cnt_t   idx, idx_next;
  bfq_pkg::cnt_t   j, j_next;
  bfq_pkg::cnt_t   dropped, dropped_next;
  logic [bfq_pkg::BYTES_W-1:0] total, total_next;
  logic            interest, interest_next;
  bfq_pkg::item_t  item, item_next;
  logic [bfq_pkg::SUM_W-1:0]   acc, acc_next;
  logic [bfq_pkg::LEN_W-1:0]   amount, amount_next;
  logic            retired, retired_next;
  bfq_pkg::status_t status, status_next;

  logic [bfq_pkg::LEN_W-1:0] head_left;
  logic [bfq_pkg::LEN_W-1:0] take;
  logic [bfq_pkg::LEN_W-1:0] sent_new;
  logic [bfq_pkg::CNT_W:0]   j_up;

  always_comb begin
    head_left = ram_rd.length - ram_rd.sent;
    take      = (item.written_bytes < head_left) ? item.written_bytes : head_left;
    sent_new  = ram_rd.sent + take;
    j_up      = {1'b0, j} + 1'b1;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    j_next        = j;
    dropped_next  = dropped;
    total_next    = total;
    interest_next = interest;
    item_next     = item;
    acc_next      = acc;
    amount_next   = amount;
    retired_next  = retired;
    status_next   = status;
    ram_req       = '0;
    alu_req       = '0;
    in_ready      = (state == bfq_pkg::S_IDLE);
    res_valid     = 1'b0;

    case (state)
      bfq_pkg::S_IDLE: begin
        if (in_valid) begin
          item_next    = in_item;
          idx_next     = '0;
          dropped_next = '0;
          retired_next = 1'b0;
          if (in_item.cmd == bfq_pkg::CMD_ENQUEUE) begin
            state_next = bfq_pkg::S_SUM;
          end else if (count == '0) begin
            status_next   = bfq_pkg::ST_DRAIN_EMPTY;
            interest_next = 1'b0;
            state_next    = bfq_pkg::S_RESULT;
          end else begin
            state_next = bfq_pkg::S_DR_RD;
          end
        end
      end

      bfq_pkg::S_SUM: begin
        alu_req.op = bfq_pkg::ALU_ADD;
        alu_req.a  = bfq_pkg::SUM_W'(total);
        alu_req.b  = bfq_pkg::SUM_W'(item.frame_length);
        acc_next   = alu_res[bfq_pkg::SUM_W-1:0];
        state_next = bfq_pkg::S_CMP;
      end

      bfq_pkg::S_CMP: begin
        // borrow set means the new frame would exceed the limit
        alu_req.op = bfq_pkg::ALU_SUB;
        alu_req.a  = bfq_pkg::SUM_W'(limit);
        alu_req.b  = acc;
        if (alu_res[bfq_pkg::SUM_W]) begin
          state_next = bfq_pkg::S_SCAN_RD;
        end else if (count >= bfq_pkg::CNT_W'(bfq_pkg::QUEUE_DEPTH)) begin
          status_next = bfq_pkg::ST_NO_SLOT;
          state_next  = bfq_pkg::S_RESULT;
        end else begin
          state_next = bfq_pkg::S_APPEND;
        end
      end

      bfq_pkg::S_SCAN_RD: begin
        if (idx >= count) begin
          status_next = bfq_pkg::ST_OVER_LIMIT;
          state_next  = bfq_pkg::S_RESULT;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx[bfq_pkg::ADDR_W-1:0];
          state_next    = bfq_pkg::S_SCAN_EV;
        end
      end

      bfq_pkg::S_SCAN_EV: begin
        if (ram_rd.low_priority) begin
          amount_next = head_left;
          state_next  = bfq_pkg::S_DEDUCT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = bfq_pkg::S_SCAN_RD;
        end
      end

      bfq_pkg::S_DEDUCT: begin
        alu_req.op   = bfq_pkg::ALU_SUB;
        alu_req.a    = bfq_pkg::SUM_W'(total);
        alu_req.b    = bfq_pkg::SUM_W'(amount);
        total_next   = alu_res[bfq_pkg::BYTES_W-1:0];
        j_next       = idx;
        dropped_next = dropped + 1'b1;
        state_next   = bfq_pkg::S_CP_RD;
      end

      bfq_pkg::S_CP_RD: begin
        // close the gap at j by moving each later entry down one place
        if (j_up < {1'b0, count}) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = j_up[bfq_pkg::ADDR_W-1:0];
          state_next    = bfq_pkg::S_CP_WR;
        end else begin
          count_next = count - 1'b1;
          if (item.cmd == bfq_pkg::CMD_ENQUEUE) begin
            state_next = bfq_pkg::S_SUM;
          end else begin
            if (count == bfq_pkg::CNT_W'(1)) begin
              interest_next = 1'b0;
            end
            state_next = bfq_pkg::S_RESULT;
          end
        end
      end

      bfq_pkg::S_CP_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j[bfq_pkg::ADDR_W-1:0];
        ram_req.wdata = ram_rd;
        j_next        = j + 1'b1;
        state_next    = bfq_pkg::S_CP_RD;
      end

      bfq_pkg::S_APPEND: begin
        ram_req.we                 = 1'b1;
        ram_req.waddr              = count[bfq_pkg::ADDR_W-1:0];
        ram_req.wdata.low_priority = item.low_priority;
        ram_req.wdata.sent         = '0;
        ram_req.wdata.length       = item.frame_length;
        alu_req.op    = bfq_pkg::ALU_ADD;
        alu_req.a     = bfq_pkg::SUM_W'(total);
        alu_req.b     = bfq_pkg::SUM_W'(item.frame_length);
        total_next    = alu_res[bfq_pkg::BYTES_W-1:0];
        count_next    = count + 1'b1;
        interest_next = 1'b1;
        status_next   = bfq_pkg::ST_ACCEPTED;
        state_next    = bfq_pkg::S_RESULT;
      end

      bfq_pkg::S_DR_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = '0;
        state_next    = bfq_pkg::S_DR_EV;
      end

      bfq_pkg::S_DR_EV: begin
        amount_next = take;
        if (sent_new == ram_rd.length) begin
          retired_next = 1'b1;
        end else begin
          ram_req.we                 = 1'b1;
          ram_req.waddr              = '0;
          ram_req.wdata.low_priority = ram_rd.low_priority;
          ram_req.wdata.sent         = sent_new;
          ram_req.wdata.length       = ram_rd.length;
        end
        state_next = bfq_pkg::S_DR_SUB;
      end

      bfq_pkg::S_DR_SUB: begin
        alu_req.op  = bfq_pkg::ALU_SUB;
        alu_req.a   = bfq_pkg::SUM_W'(total);
        alu_req.b   = bfq_pkg::SUM_W'(amount);
        total_next  = alu_res[bfq_pkg::BYTES_W-1:0];
        status_next = bfq_pkg::ST_DRAINED;
        if (retired) begin
          j_next     = '0;
          state_next = bfq_pkg::S_CP_RD;
        end else begin
          state_next = bfq_pkg::S_RESULT;
        end
      end

      bfq_pkg::S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = bfq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bfq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status         = status;
    res.dropped_frames = dropped;
    res.head_retired   = retired;
    res.queued_bytes   = total;
    res.queued_frames  = count;
    res.write_interest = interest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bfq_pkg::S_IDLE;
      count    <= '0;
      total    <= '0;
      interest <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      total    <= total_next;
      interest <= interest_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    j       <= j_next;
    dropped <= dropped_next;
    item    <= item_next;
    acc     <= acc_next;
    amount  <= amount_next;
    retired <= retired_next;
    status  <= status_next;
  end

endmodule

// ===== hdl/backpressure_frame_queue_core.sv =====
// byte-limited frame queue with low-priority drop
// s_* channel: one transaction per command; s_tuser is the command (0 enqueue,
// 1 drain), s_tdata carries frame_length, low_priority and written_bytes
// m_* channel: one result transaction per command, status in m_tuser
// cfg_* channel: writes byte_limit, always ready; the user must write it only while
// the block is idle, since the block itself does not enforce it
// the sequencer walks the slot memory one entry per step:
//   enqueue that fits: sum, limit compare, append, result
//   drain on an empty queue: straight to the result
//   drain: read, evaluate and update the head, subtract the bytes sent, and
//   when the head retires, shift every remaining frame down one place
//   enqueue under limit pressure: sum and compare per limit check, read and
//   evaluate per slot scanned, deduct and shift later frames per drop, then finish
// s_tready is high only while the sequencer is idle; one command at a time,
// the next one accepted the cycle after a result enters the output register
// a finished result sits in that register, so the next command can start
// while the receiver stalls; its result waits until the register frees
// reset empties the queue, clears write interest and restores the limit to
// 1048576; slot contents are not cleared and need no sweep
// depends on bfq_pkg, bfq_seq, bfq_alu and bfq_slot_ram

module backpressure_frame_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // frame_length[15:0], low_priority[16], written_bytes[32:17]
  input  logic        s_tuser,  // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // dropped_frames[4:0], head_retired[5], queued_bytes[29:6],
                                // queued_frames[34:30], write_interest[35]
  output logic [2:0]  m_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  logic [bfq_pkg::BYTES_W-1:0] limit;
  bfq_pkg::item_t    in_item;
  bfq_pkg::ram_req_t ram_req;
  bfq_pkg::slot_t    ram_rd;
  bfq_pkg::alu_req_t alu_req;
  logic [bfq_pkg::SUM_W:0] alu_res;
  logic              res_valid;
  logic              res_ready;
  bfq_pkg::result_t  res;
  bfq_pkg::result_t  out_res;
  logic              out_valid;
  logic [bfq_pkg::CNT_W+bfq_pkg::OUT_W-1:0] drop_ext;
  logic [bfq_pkg::CNT_W+bfq_pkg::OUT_W-1:0] frames_ext;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_item.cmd           = s_tuser;
    in_item.frame_length  = s_tdata[15:0];
    in_item.low_priority  = s_tdata[16];
    in_item.written_bytes = s_tdata[32:17];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= bfq_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  bfq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .limit     (limit),
    .ram_req   (ram_req),
    .ram_rd    (ram_rd),
    .alu_req   (alu_req),
    .alu_res   (alu_res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  bfq_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  bfq_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  // output register parts the sequencer from a stalled receiver
  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  // counts are reported modulo 32
  assign drop_ext   = {{bfq_pkg::OUT_W{1'b0}}, out_res.dropped_frames};
  assign frames_ext = {{bfq_pkg::OUT_W{1'b0}}, out_res.queued_frames};

  always_comb begin
    m_tvalid = out_valid;
    m_tuser  = out_res.status;
    m_tdata  = '0;
    m_tdata[bfq_pkg::OUT_DROP_LSB +: bfq_pkg::OUT_W]     = drop_ext[bfq_pkg::OUT_W-1:0];
    m_tdata[bfq_pkg::OUT_RETIRED_BIT]                    = out_res.head_retired;
    m_tdata[bfq_pkg::OUT_BYTES_LSB +: bfq_pkg::BYTES_W]  = out_res.queued_bytes;
    m_tdata[bfq_pkg::OUT_FRAMES_LSB +: bfq_pkg::OUT_W]   = frames_ext[bfq_pkg::OUT_W-1:0];
    m_tdata[bfq_pkg::OUT_INTEREST_BIT]                   = out_res.write_interest;
  end

endmodule

// ===== hdl/bfq_checker.sv =====
// port-level checks on the frame queue results, bound to the top level
// depends on bfq_pkg and backpressure_frame_queue_core

module bfq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // drains never report drops
  a_drain_no_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == bfq_pkg::ST_DRAINED || m_tuser == bfq_pkg::ST_DRAIN_EMPTY)
    |-> m_tdata[bfq_pkg::OUT_DROP_LSB +: bfq_pkg::OUT_W] == '0)
    else $error("drain reported dropped frames");

  // a drain that leaves nothing queued drops write interest
  a_empty_no_interest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == bfq_pkg::ST_DRAINED || m_tuser == bfq_pkg::ST_DRAIN_EMPTY)
    && m_tdata[bfq_pkg::OUT_FRAMES_LSB +: bfq_pkg::OUT_W] == '0
    |-> !m_tdata[bfq_pkg::OUT_INTEREST_BIT])
    else $error("write interest left set on empty queue");

  // an accepted enqueue wants a write and never retires a head
  a_accept_interest: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bfq_pkg::ST_ACCEPTED
    |-> m_tdata[bfq_pkg::OUT_INTEREST_BIT] && !m_tdata[bfq_pkg::OUT_RETIRED_BIT])
    else $error("accepted enqueue without write interest");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result presented after reset");

endmodule

bind backpressure_frame_queue_core bfq_checker u_bfq_checker (.*);
